// ===== rtl/core/shm_pkg.sv =====
// Shared types for the streaming histogram merge core.
package shm_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample;
        logic [5:0]         bin_index;
    } shm_in_t;

    typedef struct packed {
        logic signed [31:0] bin_centroid;
        logic [31:0]        bin_weight;
        logic               index_valid;
        logic [31:0]        total_seen;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic [6:0]         bins_used;
    } shm_out_t;

    typedef struct packed {
        logic signed [31:0] centroid;
        logic [31:0]        count;
    } shm_bin_t;

    localparam int BIN_W = $bits(shm_bin_t);

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

// ===== rtl/core/streaming_histogram_merge_core.sv =====
// Streaming histogram core: sorted weighted bins with a gap slot and nearest-pair merging.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_valid / s_ready      | shm_in_t  (cmd, sample, bin_index)
//  m_      | out       | m_valid / m_ready      | shm_out_t (one beat per input beat)
//  cfg_    | in        | cfg_valid / cfg_ready  | bin_limit, always ready
//
// A read looks up at most one slot. An observe moves the gap down or up one slot at a time
// through the single RAM read port, plus, once the bin limit is reached, a pair scan over
// the bins in use, set-up and write-back, and the serial divider.
// Reset is synchronous; the table needs no clearing pass.
// s_ready is low while an item is in work; a stalled m_ side holds only the final step.
module streaming_histogram_merge_core #(
    parameter int BIN_CAP = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  shm_pkg::shm_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output shm_pkg::shm_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [6:0]       cfg_data
);
    import shm_pkg::*;

    localparam int SLOTS  = BIN_CAP + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int AW     = $clog2(BIN_CAP + 2);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_RDW  = 4'd2;
    localparam logic [3:0] ST_LO   = 4'd3;
    localparam logic [3:0] ST_LOC  = 4'd4;
    localparam logic [3:0] ST_HI   = 4'd5;
    localparam logic [3:0] ST_HIC  = 4'd6;
    localparam logic [3:0] ST_INS  = 4'd7;
    localparam logic [3:0] ST_SCN  = 4'd8;
    localparam logic [3:0] ST_PREP = 4'd9;
    localparam logic [3:0] ST_MUL  = 4'd10;
    localparam logic [3:0] ST_DIVS = 4'd11;
    localparam logic [3:0] ST_DIV  = 4'd12;
    localparam logic [3:0] ST_MRG  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]         state_reg, state_next;
    logic [6:0]         limit_reg, limit_next;
    logic [SLOT_W-1:0]  biu_reg, biu_next;
    logic [SLOT_W-1:0]  gap_reg, gap_next;
    logic [SLOT_W-1:0]  g_reg, g_next;
    logic [31:0]        obs_reg, obs_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic               m_valid_reg, m_valid_next;
    logic [AW-1:0]      a_reg, a_next;

    shm_in_t            req_reg, req_next;
    shm_bin_t           prev_reg, prev_next;
    shm_bin_t           lo_reg, lo_next;
    shm_bin_t           hi_reg, hi_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    logic signed [32:0] bestd_reg, bestd_next;
    logic signed [31:0] ca_reg, ca_next;
    logic [31:0]        nb_reg, nb_next;
    logic [31:0]        d_reg, d_next;
    logic [32:0]        tot_reg, tot_next;
    logic [63:0]        prod_reg, prod_next;
    logic signed [31:0] res_cen_reg, res_cen_next;
    logic [31:0]        res_wt_reg, res_wt_next;
    logic               res_vld_reg, res_vld_next;
    shm_out_t           m_data_reg, m_data_next;

    logic [SLOT_W-1:0]  lim_eff;
    logic               ram_we, ram_re;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    logic [BIN_W-1:0]   ram_wdata, ram_rdata;
    shm_bin_t           rbin, wbin;
    logic               div_start, div_busy;
    logic [63:0]        div_q;
    logic [32:0]        div_r;

    logic [AW-1:0]      k;
    logic signed [32:0] diff;
    logic signed [33:0] base;
    logic signed [31:0] cb_sel;
    logic [SLOT_W-1:0]  rd_slot;

    shm_ram #(
        .WIDTH(BIN_W),
        .DEPTH(SLOTS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    shm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (tot_reg),
        .busy     (div_busy),
        .quotient (div_q),
        .remainder(div_r)
    );

    assign rbin      = shm_bin_t'(ram_rdata);
    assign ram_wdata = BIN_W'(wbin);

    always_comb begin
        if (limit_reg == 7'd0) begin
            lim_eff = SLOT_W'(1);
        end else if (32'(limit_reg) > 32'(BIN_CAP)) begin
            lim_eff = SLOT_W'(BIN_CAP);
        end else begin
            lim_eff = SLOT_W'(limit_reg);
        end
    end

    always_comb begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        biu_next     = biu_reg;
        gap_next     = gap_reg;
        g_next       = g_reg;
        obs_next     = obs_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        m_valid_next = m_valid_reg;
        a_next       = a_reg;
        req_next     = req_reg;
        prev_next    = prev_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        best_next    = best_reg;
        bestd_next   = bestd_reg;
        ca_next      = ca_reg;
        nb_next      = nb_reg;
        d_next       = d_reg;
        tot_next     = tot_reg;
        prod_next    = prod_reg;
        res_cen_next = res_cen_reg;
        res_wt_next  = res_wt_reg;
        res_vld_next = res_vld_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = g_reg;
        ram_raddr    = g_reg;
        wbin         = rbin;
        div_start    = 1'b0;
        k            = a_reg - AW'(1);
        diff         = {rbin.centroid[31], rbin.centroid}
                     - {prev_reg.centroid[31], prev_reg.centroid};
        base         = {{2{ca_reg[31]}}, ca_reg} + {2'b00, div_q[31:0]};
        cb_sel       = lo_reg.centroid;
        rd_slot      = (32'(req_reg.bin_index) < 32'(gap_reg))
                     ? SLOT_W'(req_reg.bin_index) : SLOT_W'(32'(req_reg.bin_index) + 1);

        if (cfg_valid) begin
            limit_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    res_cen_next = '0;
                    res_wt_next  = '0;
                    res_vld_next = 1'b0;
                    if (s_data.cmd == CMD_READ) begin
                        state_next = ST_RD;
                    end else begin
                        obs_next   = (obs_reg == COUNT_MAX) ? obs_reg : obs_reg + 32'd1;
                        min_next   = (s_data.sample < min_reg) ? s_data.sample : min_reg;
                        max_next   = (s_data.sample > max_reg) ? s_data.sample : max_reg;
                        g_next     = (gap_reg > biu_reg) ? biu_reg : gap_reg;
                        state_next = ST_LO;
                    end
                end
            end
            ST_RD: begin
                if (32'(req_reg.bin_index) < 32'(biu_reg)) begin
                    ram_re     = 1'b1;
                    ram_raddr  = rd_slot;
                    state_next = ST_RDW;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RDW: begin
                res_cen_next = rbin.centroid;
                res_wt_next  = rbin.count;
                res_vld_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_LO: begin
                if (g_reg == '0) begin
                    state_next = ST_HI;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = g_reg - SLOT_W'(1);
                    state_next = ST_LOC;
                end
            end
            ST_LOC: begin
                if (rbin.centroid > req_reg.sample) begin
                    ram_we     = 1'b1;
                    ram_waddr  = g_reg;
                    g_next     = g_reg - SLOT_W'(1);
                    state_next = ST_LO;
                end else if (rbin.centroid == req_reg.sample) begin
                    ram_we     = 1'b1;
                    ram_waddr  = g_reg - SLOT_W'(1);
                    wbin.count = (rbin.count == COUNT_MAX) ? rbin.count : rbin.count + 32'd1;
                    gap_next   = g_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                if (g_reg >= biu_reg) begin
                    state_next = ST_INS;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = g_reg + SLOT_W'(1);
                    state_next = ST_HIC;
                end
            end
            ST_HIC: begin
                if (rbin.centroid < req_reg.sample) begin
                    ram_we     = 1'b1;
                    ram_waddr  = g_reg;
                    g_next     = g_reg + SLOT_W'(1);
                    state_next = ST_LO;
                end else if (rbin.centroid == req_reg.sample) begin
                    ram_we     = 1'b1;
                    ram_waddr  = g_reg + SLOT_W'(1);
                    wbin.count = (rbin.count == COUNT_MAX) ? rbin.count : rbin.count + 32'd1;
                    gap_next   = g_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                ram_we        = 1'b1;
                ram_waddr     = g_reg;
                wbin.centroid = req_reg.sample;
                wbin.count    = 32'd1;
                if (biu_reg < lim_eff) begin
                    biu_next   = biu_reg + SLOT_W'(1);
                    gap_next   = biu_reg + SLOT_W'(1);
                    state_next = ST_DONE;
                end else begin
                    a_next     = '0;
                    state_next = ST_SCN;
                end
            end
            ST_SCN: begin
                if (32'(a_reg) <= 32'(biu_reg)) begin
                    ram_re    = 1'b1;
                    ram_raddr = SLOT_W'(a_reg);
                end
                a_next = a_reg + AW'(1);
                if (a_reg != '0) begin
                    prev_next = rbin;
                    if (k != '0) begin
                        if (k == AW'(1) || diff < bestd_reg) begin
                            bestd_next = diff;
                            best_next  = SLOT_W'(k - AW'(1));
                            lo_next    = prev_reg;
                            hi_next    = rbin;
                        end
                    end
                    if (32'(k) == 32'(biu_reg)) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (hi_reg.centroid < lo_reg.centroid) begin
                    ca_next = hi_reg.centroid;
                    cb_sel  = lo_reg.centroid;
                    nb_next = lo_reg.count;
                end else begin
                    ca_next = lo_reg.centroid;
                    cb_sel  = hi_reg.centroid;
                    nb_next = hi_reg.count;
                end
                d_next     = 32'({cb_sel[31], cb_sel} - {ca_next[31], ca_next});
                tot_next   = {1'b0, lo_reg.count} + {1'b0, hi_reg.count};
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = d_reg * nb_reg;
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_MRG;
                end
            end
            ST_MRG: begin
                ram_we    = 1'b1;
                ram_waddr = best_reg + SLOT_W'(1);
                if (tot_reg == '0) begin
                    wbin.centroid = ca_reg;
                end else if (div_r != '0 && base[33]) begin
                    wbin.centroid = 32'(base + 34'sd1);
                end else begin
                    wbin.centroid = base[31:0];
                end
                wbin.count = tot_reg[32] ? COUNT_MAX : tot_reg[31:0];
                gap_next   = best_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.bin_centroid = res_cen_reg;
                    m_data_next.bin_weight   = res_wt_reg;
                    m_data_next.index_valid  = res_vld_reg;
                    m_data_next.total_seen   = obs_reg;
                    m_data_next.smallest     = min_reg;
                    m_data_next.largest      = max_reg;
                    m_data_next.bins_used    = 7'(biu_reg);
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= 7'd64;
            biu_reg     <= '0;
            gap_reg     <= '0;
            obs_reg     <= '0;
            min_reg     <= 32'sh7FFF_FFFF;
            max_reg     <= 32'sh8000_0000;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            biu_reg     <= biu_next;
            gap_reg     <= gap_next;
            obs_reg     <= obs_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg       <= g_next;
        a_reg       <= a_next;
        req_reg     <= req_next;
        prev_reg    <= prev_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        best_reg    <= best_next;
        bestd_reg   <= bestd_next;
        ca_reg      <= ca_next;
        nb_reg      <= nb_next;
        d_reg       <= d_next;
        tot_reg     <= tot_next;
        prod_reg    <= prod_next;
        res_cen_reg <= res_cen_next;
        res_wt_reg  <= res_wt_next;
        res_vld_reg <= res_vld_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/shm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module shm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/shm_div.sv =====
// Radix-2 restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
module shm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic [63:0] quotient,
    output logic [32:0] remainder
);

    logic [33:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] shifted;
    logic        take;

    always_comb begin
        shifted   = {rem_reg[32:0], quo_reg[63]};
        take      = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = take ? (shifted - {1'b0, divisor}) : shifted;
            quo_next  = {quo_reg[62:0], take};
            cnt_next  = cnt_reg - 7'd1;
            busy_next = cnt_reg != 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[32:0];

endmodule

// ===== rtl/core/shm_checker.sv =====
// Port-level checks for the streaming histogram merge core, with its bind.
module shm_checker #(
    parameter int BIN_CAP = 64
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input shm_pkg::shm_out_t m_data
);
    import shm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before item finished");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.index_valid |-> m_data.bin_centroid == 0 && m_data.bin_weight == 0)
        else $error("bin fields non-zero without a valid index");

    a_bins_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.bins_used) <= 32'(BIN_CAP))
        else $error("bins in use beyond table size");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.total_seen != 0 |-> m_data.smallest <= m_data.largest)
        else $error("running minimum above running maximum");

endmodule

bind streaming_histogram_merge_core shm_checker #(.BIN_CAP(BIN_CAP)) u_shm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

// ===== tb/streaming_histogram_merge_core_test.sv =====
// Self-checking testbench for the streaming histogram merge core.
`timescale 1ns / 100ps

module streaming_histogram_merge_core_test;
    import shm_pkg::*;

    localparam int BIN_CAP     = 64;
    localparam int SLOTS       = BIN_CAP + 1;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 500;
    localparam int N_RANDOM    = 2000;
    localparam int N_DIRECTED  = 14;

    typedef struct {
        shm_in_t  stim;
        bit       has_exp;
        shm_out_t exp_out;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    shm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    shm_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [6:0] cfg_data = 7'd64;

    logic signed [31:0] hist_cen [SLOTS];
    logic [31:0]        hist_cnt [SLOTS];
    int unsigned        hist_gap;
    int unsigned        hist_used;
    logic [31:0]        hist_total;
    logic signed [31:0] hist_min;
    logic signed [31:0] hist_max;
    logic [6:0]         hist_limit;

    shm_out_t    pending_results[$];
    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;
    int unsigned read_hits = 0;
    int unsigned merges = 0;

    streaming_histogram_merge_core #(.BIN_CAP(BIN_CAP)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic signed [31:0] weighted_mean(logic signed [31:0] ca,
            logic [31:0] na, logic signed [31:0] cb, logic [31:0] nb);
        logic signed [31:0] tc;
        logic [31:0]        tn;
        logic [63:0]        tot;
        logic [63:0]        d;
        logic [95:0]        prod;
        logic [95:0]        q;
        logic [95:0]        r;
        longint             base;
        if (cb < ca) begin
            tc = ca; tn = na; ca = cb; na = nb; cb = tc; nb = tn;
        end
        tot = {32'd0, na} + {32'd0, nb};
        if (tot == 0) return ca;
        d = 64'(longint'(cb) - longint'(ca));
        prod = {32'd0, d} * {64'd0, nb};
        q = prod / {32'd0, tot};
        r = prod % {32'd0, tot};
        base = longint'(ca) + longint'(q[63:0]);
        if (r != 0 && base < 0) base = base + 1;
        return base[31:0];
    endfunction

    function automatic void histogram_observe(logic signed [31:0] x);
        int unsigned g;
        int unsigned lim;
        int unsigned best;
        longint      best_d;
        longint      dlt;
        hist_total = sat_inc(hist_total, 1);
        if (x < hist_min) hist_min = x;
        if (x > hist_max) hist_max = x;
        g = (hist_gap > hist_used) ? hist_used : hist_gap;
        forever begin
            if (g != 0) begin
                if (hist_cen[g-1] > x) begin
                    hist_cen[g] = hist_cen[g-1];
                    hist_cnt[g] = hist_cnt[g-1];
                    g--;
                    continue;
                end
                if (hist_cen[g-1] == x) begin
                    hist_cnt[g-1] = sat_inc(hist_cnt[g-1], 1);
                    hist_gap = g;
                    return;
                end
            end
            if (g < hist_used) begin
                if (hist_cen[g+1] < x) begin
                    hist_cen[g] = hist_cen[g+1];
                    hist_cnt[g] = hist_cnt[g+1];
                    g++;
                    continue;
                end
                if (hist_cen[g+1] == x) begin
                    hist_cnt[g+1] = sat_inc(hist_cnt[g+1], 1);
                    hist_gap = g;
                    return;
                end
            end
            break;
        end
        hist_cen[g] = x;
        hist_cnt[g] = 1;
        lim = hist_limit;
        if (lim < 1) lim = 1;
        if (lim > BIN_CAP) lim = BIN_CAP;
        if (hist_used < lim) begin
            hist_used++;
            hist_gap = hist_used;
            return;
        end
        merges++;
        best = 0;
        best_d = longint'(hist_cen[1]) - longint'(hist_cen[0]);
        for (int i = 1; i < hist_used; i++) begin
            dlt = longint'(hist_cen[i+1]) - longint'(hist_cen[i]);
            if (dlt < best_d) begin
                best_d = dlt;
                best = i;
            end
        end
        hist_cen[best+1] = weighted_mean(hist_cen[best], hist_cnt[best],
                                         hist_cen[best+1], hist_cnt[best+1]);
        hist_cnt[best+1] = sat_inc(hist_cnt[best+1], hist_cnt[best]);
        hist_gap = best;
    endfunction

    function automatic shm_out_t histogram_step(shm_in_t it);
        shm_out_t o;
        int unsigned s;
        o = '0;
        if (it.cmd == CMD_OBSERVE) begin
            histogram_observe(it.sample);
        end else if (it.bin_index < hist_used) begin
            s = (it.bin_index < hist_gap) ? it.bin_index : it.bin_index + 1;
            o.bin_centroid = hist_cen[s];
            o.bin_weight   = hist_cnt[s];
            o.index_valid  = 1'b1;
            read_hits++;
        end
        o.total_seen = hist_total;
        o.smallest   = hist_min;
        o.largest    = hist_max;
        o.bins_used  = 7'(hist_used);
        return o;
    endfunction

    // receive side: random stalls, compare against oldest expectation
    int unsigned stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat");
                fail_count++;
            end else begin
                shm_out_t e;
                e = pending_results.pop_front();
                if (m_data.bin_centroid !== e.bin_centroid) begin
                    $error("bin_centroid exp %0d got %0d", e.bin_centroid, m_data.bin_centroid);
                    fail_count++;
                end
                if (m_data.bin_weight !== e.bin_weight) begin
                    $error("bin_weight exp %0d got %0d", e.bin_weight, m_data.bin_weight);
                    fail_count++;
                end
                if (m_data.index_valid !== e.index_valid) begin
                    $error("index_valid exp %0d got %0d", e.index_valid, m_data.index_valid);
                    fail_count++;
                end
                if (m_data.total_seen !== e.total_seen) begin
                    $error("total_seen exp %0d got %0d", e.total_seen, m_data.total_seen);
                    fail_count++;
                end
                if (m_data.smallest !== e.smallest) begin
                    $error("smallest exp %0d got %0d", e.smallest, m_data.smallest);
                    fail_count++;
                end
                if (m_data.largest !== e.largest) begin
                    $error("largest exp %0d got %0d", e.largest, m_data.largest);
                    fail_count++;
                end
                if (m_data.bins_used !== e.bins_used) begin
                    $error("bins_used exp %0d got %0d", e.bins_used, m_data.bins_used);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(shm_in_t it, bit has_exp, shm_out_t exp_out);
        shm_out_t p;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        p = histogram_step(it);
        if (has_exp && p !== exp_out) begin
            $error("directed row disagrees with predictor");
            fail_count++;
        end
        pending_results.push_back(p);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(logic [6:0] v);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hist_limit = v;
    endtask

    function automatic shm_in_t mk_obs(logic signed [31:0] x);
        shm_in_t t;
        t = '0;
        t.cmd = CMD_OBSERVE;
        t.sample = x;
        t.bin_index = 6'($urandom);
        return t;
    endfunction

    function automatic shm_in_t mk_read(logic [5:0] idx);
        shm_in_t t;
        t = '0;
        t.cmd = CMD_READ;
        t.sample = $urandom;
        t.bin_index = idx;
        return t;
    endfunction

    function automatic shm_out_t mk_out(logic signed [31:0] c, logic [31:0] w, logic v,
            logic [31:0] n, logic signed [31:0] lo, logic signed [31:0] hi, logic [6:0] u);
        shm_out_t o;
        o.bin_centroid = c; o.bin_weight = w; o.index_valid = v;
        o.total_seen = n; o.smallest = lo; o.largest = hi; o.bins_used = u;
        return o;
    endfunction

    function automatic logic signed [31:0] pick_sample(int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return 32'sd65536 * $signed($urandom_range(0, 40)) - 32'sd1310720;
            2: return $signed($urandom_range(0, 16)) - 32'sd8;
            3: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                   : 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
        endcase
    endfunction

    dir_row_t directed[N_DIRECTED];
    shm_out_t zero_out;

    initial begin
        int unsigned mode;
        logic [6:0] limits[6];
        zero_out = '0;
        hist_used = 0; hist_gap = 0; hist_total = 0;
        hist_min = 32'sh7FFF_FFFF; hist_max = 32'sh8000_0000; hist_limit = 7'd64;
        for (int i = 0; i < SLOTS; i++) begin
            hist_cen[i] = '0;
            hist_cnt[i] = '0;
        end

        directed[0]  = '{mk_read(6'd0), 1'b1,
                         mk_out(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0)};
        directed[1]  = '{mk_read(6'd63), 1'b1,
                         mk_out(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0)};
        directed[2]  = '{mk_obs(32'sh7FFF_FFFF), 1'b1,
                         mk_out(0, 0, 0, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1)};
        directed[3]  = '{mk_obs(32'sh8000_0000), 1'b1,
                         mk_out(0, 0, 0, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 2)};
        directed[4]  = '{mk_read(6'd0), 1'b1,
                         mk_out(32'sh8000_0000, 1, 1, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 2)};
        directed[5]  = '{mk_read(6'd1), 1'b1,
                         mk_out(32'sh7FFF_FFFF, 1, 1, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 2)};
        directed[6]  = '{mk_read(6'd2), 1'b1,
                         mk_out(0, 0, 0, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 2)};
        directed[7]  = '{mk_obs(32'sh7FFF_FFFF), 1'b0, zero_out};
        directed[8]  = '{mk_obs(32'sd0), 1'b0, zero_out};
        directed[9]  = '{mk_obs(-32'sd1), 1'b0, zero_out};
        directed[10] = '{mk_obs(32'sd0), 1'b0, zero_out};
        directed[11] = '{mk_read(6'd1), 1'b0, zero_out};
        directed[12] = '{mk_read(6'd2), 1'b0, zero_out};
        directed[13] = '{mk_read(6'd4), 1'b0, zero_out};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_item(directed[i].stim, directed[i].has_exp,
                                        directed[i].exp_out);

        // limit 1 and 0 collapse to one bin, then merges with a wide table
        write_limit(7'd1);
        for (int i = 0; i < 6; i++) send_item(mk_obs(pick_sample(i % 5)), 0, zero_out);
        send_item(mk_read(6'd0), 0, zero_out);
        write_limit(7'd0);
        for (int i = 0; i < 4; i++) send_item(mk_obs(pick_sample(0)), 0, zero_out);
        send_item(mk_read(6'd0), 0, zero_out);

        limits = '{7'd127, 7'd3, 7'd64, 7'd8, 7'd2, 7'd64};
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            calm = (ph == 5);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_item(mk_read(($urandom_range(0, 3) == 0) ? 6'($urandom)
                              : 6'($urandom_range(0, hist_used))), 0, zero_out);
                end else begin
                    mode = (ph == 0 && i < 70) ? 2 : $urandom_range(0, 4);
                    send_item(mk_obs(pick_sample(mode)), 0, zero_out);
                end
                if (ph == 2 && i == 50) begin
                    wait_drained();
                end
            end
            // read back the whole table
            for (int b = 0; b <= hist_used && b < 64; b++)
                send_item(mk_read(6'(b)), 0, zero_out);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d results, %0d bin hits, %0d merges, limits 0..127.",
                 results_seen, read_hits, merges);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
